// File: rtl/dhns_pkg.sv
// Shared types and constants for the decimal/hex number scanner.
// No dependencies; used by every module of the block.
package dhns_pkg;

   // Default cap on the consumed-length count
   localparam logic [31:0] MaxScanLengthDefault = 32'd65535;

   // Entries in the queue between front and back
   localparam int QueueDepth = 4;

   // Character codes
   localparam logic [7:0] CharNul   = 8'h00;
   localparam logic [7:0] CharTab   = 8'h09;
   localparam logic [7:0] CharCr    = 8'h0D;
   localparam logic [7:0] CharSpace = 8'h20;
   localparam logic [7:0] CharComma = 8'h2C;
   localparam logic [7:0] CharMinus = 8'h2D;
   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [7:0] CharNine  = 8'h39;
   localparam logic [7:0] CharUpA   = 8'h41;
   localparam logic [7:0] CharUpF   = 8'h46;
   localparam logic [7:0] CharUpX   = 8'h58;
   localparam logic [7:0] CharLoA   = 8'h61;
   localparam logic [7:0] CharLoF   = 8'h66;
   localparam logic [7:0] CharLoX   = 8'h78;

   // Input request
   typedef struct packed {
      logic [7:0] char_byte;
      logic       field_start;
   } dhns_req_type;

   // Result
   typedef struct packed {
      logic        ok;
      logic [31:0] number_value;
      logic [15:0] scanned_length;
      logic        was_hex;
   } dhns_rsp_type;

   // Classified character, as queued between front and back
   typedef struct packed {
      logic       field_start;
      logic       is_white;
      logic       is_zero;
      logic       is_x;
      logic       is_minus;
      logic       is_nul;
      logic       is_sep;
      logic       is_dec;
      logic       is_hex;
      logic [3:0] digit;
   } dhns_class_type;

   // Scan phase
   typedef enum logic [2:0] {
      PH_IDLE,
      PH_WHITE,
      PH_ZERO,
      PH_HEXWHITE,
      PH_HEX,
      PH_DEC,
      PH_DONE
   } phase_type;

endpackage

// File: rtl/dhns_front.sv
// Front end: classifies each incoming character for the scan engine.
// Depends on dhns_pkg.
module dhns_front (
   input  dhns_pkg::dhns_req_type   req_item,
   output dhns_pkg::dhns_class_type cls_item
);

   logic [7:0] c;
   logic       lower_hex;
   logic       upper_hex;

   assign c = req_item.char_byte;

   // Hex letter ranges
   assign lower_hex = (c >= dhns_pkg::CharLoA) && (c <= dhns_pkg::CharLoF);
   assign upper_hex = (c >= dhns_pkg::CharUpA) && (c <= dhns_pkg::CharUpF);

   // Character classes
   always_comb begin
      cls_item.field_start = req_item.field_start;
      cls_item.is_white    = (c == dhns_pkg::CharSpace) ||
                             ((c >= dhns_pkg::CharTab) && (c <= dhns_pkg::CharCr));
      cls_item.is_zero     = (c == dhns_pkg::CharZero);
      cls_item.is_x        = (c == dhns_pkg::CharLoX) || (c == dhns_pkg::CharUpX);
      cls_item.is_minus    = (c == dhns_pkg::CharMinus);
      cls_item.is_nul      = (c == dhns_pkg::CharNul);
      cls_item.is_sep      = (c == dhns_pkg::CharTab) || (c == dhns_pkg::CharComma) ||
                             (c == dhns_pkg::CharSpace);
      cls_item.is_dec      = (c >= dhns_pkg::CharZero) && (c <= dhns_pkg::CharNine);
      cls_item.is_hex      = cls_item.is_dec || lower_hex || upper_hex;
      // '0'..'9' carry their value in the low nibble; 'a'/'A' have low nibble 1
      cls_item.digit       = cls_item.is_dec ? c[3:0] : (c[3:0] + 4'd9);
   end

endmodule

// File: rtl/dhns_queue.sv
// Small queue of classified characters between front and back.
// Depends on dhns_pkg.
module dhns_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   output logic                     push_ready,
   input  dhns_pkg::dhns_class_type push_item,
   output logic                     pop_valid,
   input  logic                     pop_ready,
   output dhns_pkg::dhns_class_type pop_item
);

   localparam int PtrW = $clog2(dhns_pkg::QueueDepth);
   localparam int CntW = $clog2(dhns_pkg::QueueDepth + 1);

   dhns_pkg::dhns_class_type entry_ff [dhns_pkg::QueueDepth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            push;
   logic            pop;

   assign push_ready = (cnt_ff != CntW'(dhns_pkg::QueueDepth));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? (wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? (rd_ptr_ff + 1'b1) : rd_ptr_ff;
      cnt_in    = cnt_ff + CntW'(push) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: rtl/dhns_back.sv
// Back end: scan state machine, accumulator, length counter and result register.
// Depends on dhns_pkg.
module dhns_back #(
   parameter logic [31:0] MAX_SCAN_LENGTH = dhns_pkg::MaxScanLengthDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   output logic                     q_pop,
   input  dhns_pkg::dhns_class_type q_item,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output dhns_pkg::dhns_rsp_type   rsp_data
);

   localparam logic [15:0] LenCap =
      (MAX_SCAN_LENGTH < 32'd65535) ? MAX_SCAN_LENGTH[15:0] : 16'hFFFF;

   dhns_pkg::phase_type    phase_ff, phase_in, eff_phase;
   logic [31:0]            acc_ff, acc_in, eff_acc;
   logic [15:0]            cnt_ff, cnt_in, eff_cnt;
   logic                   neg_ff, neg_in, eff_neg;
   logic                   any_ff, any_in, eff_any;
   logic                   rsp_valid_ff, rsp_valid_in;
   dhns_pkg::dhns_rsp_type rsp_ff, rsp_in;

   logic        out_free;
   logic        in_white, in_zero, in_hexwhite, in_hex, in_dec;
   logic        do_dec, do_hex, dec_stop, hex_stop, fire, ok, base_any;
   logic        inc_ws, inc_minus, inc_x2, inc_zero_digit, inc_digit;
   logic [1:0]  step_n;
   logic [16:0] cnt_sum;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign q_pop    = q_valid && out_free;

   // A field start drops any scan in progress
   assign eff_phase = q_item.field_start ? dhns_pkg::PH_WHITE : phase_ff;
   assign eff_acc   = q_item.field_start ? '0 : acc_ff;
   assign eff_cnt   = q_item.field_start ? '0 : cnt_ff;
   assign eff_neg   = q_item.field_start ? 1'b0 : neg_ff;
   assign eff_any   = q_item.field_start ? 1'b0 : any_ff;

   assign in_white    = (eff_phase == dhns_pkg::PH_WHITE);
   assign in_zero     = (eff_phase == dhns_pkg::PH_ZERO);
   assign in_hexwhite = (eff_phase == dhns_pkg::PH_HEXWHITE);
   assign in_hex      = (eff_phase == dhns_pkg::PH_HEX);
   assign in_dec      = (eff_phase == dhns_pkg::PH_DEC);

   // Which digit path handles this character
   assign do_dec = (in_white && !q_item.is_white && !q_item.is_zero && !q_item.is_nul &&
                    !q_item.is_minus) || (in_zero && !q_item.is_x) || in_dec;
   assign do_hex = (in_hexwhite && !q_item.is_white) || in_hex;

   // A lone '0' counts as a decimal digit
   assign base_any = eff_any || in_zero;
   assign dec_stop = do_dec && !q_item.is_dec;
   assign hex_stop = do_hex && !q_item.is_hex;
   assign fire     = (in_white && q_item.is_nul) || dec_stop || hex_stop;

   always_comb begin
      if (hex_stop) begin
         ok = base_any;
      end else if (dec_stop) begin
         ok = q_item.is_nul || (q_item.is_sep && base_any);
      end else begin
         ok = 1'b0;
      end
   end

   // Consumed-byte increments
   assign inc_ws         = (in_white || in_hexwhite) && q_item.is_white;
   assign inc_minus      = in_white && q_item.is_minus;
   assign inc_x2         = in_zero && q_item.is_x;
   assign inc_zero_digit = in_zero && !q_item.is_x;
   assign inc_digit      = (do_dec && q_item.is_dec) || (do_hex && q_item.is_hex);
   assign step_n  = 2'(inc_ws) + 2'(inc_minus) + {inc_x2, 1'b0} + 2'(inc_zero_digit) +
                    2'(inc_digit);
   assign cnt_sum = {1'b0, eff_cnt} + 17'(step_n);

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (q_pop) begin
         case (eff_phase)
            dhns_pkg::PH_WHITE: begin
               if (fire)                 phase_in = dhns_pkg::PH_DONE;
               else if (q_item.is_white) phase_in = dhns_pkg::PH_WHITE;
               else if (q_item.is_zero)  phase_in = dhns_pkg::PH_ZERO;
               else                      phase_in = dhns_pkg::PH_DEC;
            end
            dhns_pkg::PH_ZERO: begin
               if (q_item.is_x)  phase_in = dhns_pkg::PH_HEXWHITE;
               else if (fire)    phase_in = dhns_pkg::PH_DONE;
               else              phase_in = dhns_pkg::PH_DEC;
            end
            dhns_pkg::PH_HEXWHITE: begin
               if (q_item.is_white) phase_in = dhns_pkg::PH_HEXWHITE;
               else if (fire)       phase_in = dhns_pkg::PH_DONE;
               else                 phase_in = dhns_pkg::PH_HEX;
            end
            dhns_pkg::PH_HEX: phase_in = fire ? dhns_pkg::PH_DONE : dhns_pkg::PH_HEX;
            dhns_pkg::PH_DEC: phase_in = fire ? dhns_pkg::PH_DONE : dhns_pkg::PH_DEC;
            dhns_pkg::PH_DONE: phase_in = dhns_pkg::PH_DONE;
            default:           phase_in = dhns_pkg::PH_IDLE;
         endcase
      end
   end

   // Datapath and result
   always_comb begin
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      neg_in = neg_ff;
      any_in = any_ff;
      if (q_pop) begin
         if (do_dec && q_item.is_dec) begin
            acc_in = (eff_acc << 3) + (eff_acc << 1) + 32'(q_item.digit);
         end else if (do_hex && q_item.is_hex) begin
            acc_in = {eff_acc[27:0], q_item.digit};
         end else begin
            acc_in = eff_acc;
         end
         cnt_in = (cnt_sum > {1'b0, LenCap}) ? LenCap : cnt_sum[15:0];
         neg_in = eff_neg || inc_minus;
         any_in = eff_any || inc_zero_digit || inc_digit;
      end

      rsp_in.ok             = ok;
      rsp_in.number_value   = (ok && eff_neg) ? (32'd0 - eff_acc) : eff_acc;
      rsp_in.scanned_length = (cnt_sum > {1'b0, LenCap}) ? LenCap : cnt_sum[15:0];
      rsp_in.was_hex        = hex_stop;

      if (q_pop && fire)  rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else                rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= dhns_pkg::PH_IDLE;
         acc_ff       <= '0;
         cnt_ff       <= '0;
         neg_ff       <= 1'b0;
         any_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         neg_ff       <= neg_in;
         any_ff       <= any_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (q_pop && fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   // Finished scan stays finished until a new field starts
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == dhns_pkg::PH_DONE) && !(q_pop && q_item.field_start)
      |=> (phase_ff == dhns_pkg::PH_DONE))
      else $error("scan left DONE without a field start");

   // No digits accumulated before the digit phases
   a_acc_clear: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == dhns_pkg::PH_WHITE || phase_ff == dhns_pkg::PH_ZERO ||
       phase_ff == dhns_pkg::PH_HEXWHITE) |-> (acc_ff == '0))
      else $error("accumulator nonzero before digits");

   // Length count respects the cap
   a_cnt_cap: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= LenCap)
      else $error("consumed count above cap");

   // A new result appears only from a popped stop character
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(q_pop && fire))
      else $error("result without a stop character");
`endif

endmodule

// File: rtl/decimal_hex_number_scanner_core.sv
// Top level of the decimal/hex number scanner.
// Depends on dhns_pkg, dhns_front, dhns_queue and dhns_back.
//
// Usage:
//   req_ channel carries one character per request (char_byte) with a
//   field_start flag that opens a new field and drops any scan in progress.
//   rsp_ channel carries at most one result per field: ok, number_value,
//   scanned_length and was_hex, issued at the character that stops the scan.
//   Characters after the stop character are dropped until the next start.
// Throughput: one character per cycle while no result is held; the accumulator
//   shift-add in the back end is combinational.
// Result path: the stop character is registered in a queue entry, then in the
//   result register, where rsp_valid rises; a held result or earlier queued
//   characters can hold it back in the queue.
// Stalls: a held result blocks the back end; the 4-entry queue keeps
//   accepting until full, then req_ready drops.
// Reset: synchronous; clears the queue, the result valid flag and the scan
//   state to idle, so characters are ignored until a field start.
module decimal_hex_number_scanner_core #(
   parameter logic [31:0] MAX_SCAN_LENGTH = dhns_pkg::MaxScanLengthDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  dhns_pkg::dhns_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output dhns_pkg::dhns_rsp_type rsp_data
);

   dhns_pkg::dhns_class_type cls_item;
   dhns_pkg::dhns_class_type q_item;
   logic                     q_valid;
   logic                     q_pop;

   // Character classification
   dhns_front u_front (
      .req_item (req_data),
      .cls_item (cls_item)
   );

   // Decoupling queue
   dhns_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_item  (cls_item),
      .pop_valid  (q_valid),
      .pop_ready  (q_pop),
      .pop_item   (q_item)
   );

   // Scan engine
   dhns_back #(
      .MAX_SCAN_LENGTH (MAX_SCAN_LENGTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_item    (q_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
